// ===== sv/irt_pkg.sv =====
// Package for the interval reservation table: field types, entry type,
// operation and status codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none
package irt_pkg;

  localparam int CAPACITY_DEF = 32;
  localparam int MAX_OUT = 32;

  localparam logic [1:0] FN_CREATE = 2'd0;
  localparam logic [1:0] FN_DELETE = 2'd1;
  localparam logic [1:0] FN_QUERY  = 2'd2;
  localparam logic [1:0] FN_LIST   = 2'd3;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_BAD_RANGE     = 3'd1;
  localparam logic [2:0] ST_OVERLAP       = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND     = 3'd3;
  localparam logic [2:0] ST_FULL          = 3'd4;
  localparam logic [2:0] ST_IDS_EXHAUSTED = 3'd5;
  localparam logic [2:0] ST_NO_EVENTS     = 3'd6;

  typedef struct packed {
    logic [1:0]  func;
    logic [31:0] start_time;
    logic [31:0] end_time;
    logic [15:0] target_id;
  } irt_in_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [15:0] entry_id;
    logic [31:0] start_out;
    logic [31:0] end_out;
    logic        last;
  } irt_out_t;

  typedef struct packed {
    logic [31:0] s;
    logic [31:0] e;
    logic [15:0] id;
  } irt_ent_t;

endpackage
`default_nettype wire

// ===== sv/irt_mem.sv =====
// Entry memory of the interval reservation table: one write port and one
// registered read port. Depends on irt_pkg for the entry type.
`timescale 1ns / 1ps
`default_nettype none
module irt_mem
  import irt_pkg::*;
#(
  parameter int DEPTH = CAPACITY_DEF,
  parameter int AW = $clog2(DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire irt_ent_t      wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output irt_ent_t           rd_data
);

  irt_ent_t mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port: the data for an address appears in the cycle after it.
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

// ===== sv/interval_reservation_table_top.sv =====
// Top level of the interval reservation table: command sequencer around
// the sorted entry memory. Depends on irt_pkg and irt_mem.
//
// Usage: an operation transfers in at a clock edge where start is high and
// busy is low (in_item: func, start_time, end_time, target_id). Results come
// on out_item with a one-cycle strobe out_valid; the final result of an
// operation has last set. The receiver cannot stall, so results are simply
// presented once.
// Entries are held in one memory in ascending start order. Except for a
// bad range create, an operation walks the table with one read (S_SC_RD)
// and one check (S_SC_CK) per stored entry. The steps of each operation:
//   bad range create: answered at once, with no walk;
//   overlap create: walk up to the clashing entry, then the error result;
//   full or ids exhausted create: full walk, then the error result in S_END;
//   create: full walk, later entries moved up (S_SH_RD, S_SH_WR), then S_INS;
//   delete: walk up to the match, which is answered there, then busy while
//     the later entries move down, or a full walk and not found if absent;
//   query/list: walk to the end or MAX_OUT results, results during the walk.
// Throughput is one operation at a time; busy stays high until the operation,
// including any entry moves, has finished.
// Reset clears the entry count and sets the next id to one; the memory
// needs no clearing since only the first count entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
module interval_reservation_table_top
  import irt_pkg::*;
#(
  parameter int CAPACITY = CAPACITY_DEF
) (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    start,
  output logic         busy,
  input  wire irt_in_t in_item,
  output logic         out_valid,
  output irt_out_t     out_item
);

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int CW = $clog2(CAPACITY + 1);
  localparam int HW = $clog2(MAX_OUT + 1);
  localparam logic [CW-1:0] CAP = CW'(CAPACITY);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SC_RD = 3'd1;
  localparam logic [2:0] S_SC_CK = 3'd2;
  localparam logic [2:0] S_END   = 3'd3;
  localparam logic [2:0] S_SH_RD = 3'd4;
  localparam logic [2:0] S_SH_WR = 3'd5;
  localparam logic [2:0] S_INS   = 3'd6;

  logic [2:0]    state_r, state_nxt;
  irt_in_t       cmd_r, cmd_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [15:0]   next_id_r, next_id_nxt;
  logic [CW-1:0] idx_r, idx_nxt;
  logic [CW-1:0] j_r, j_nxt;
  logic [CW-1:0] pos_r, pos_nxt;
  logic          pos_found_r, pos_found_nxt;
  logic [HW-1:0] hits_r, hits_nxt;
  logic          pend_r, pend_nxt;
  irt_ent_t      pend_ent_r, pend_ent_nxt;
  logic          out_valid_r, out_valid_nxt;
  irt_out_t      out_r, out_nxt;

  logic          wr_en;
  logic [AW-1:0] wr_addr;
  irt_ent_t      wr_data;
  logic [AW-1:0] rd_addr;
  irt_ent_t      rd_data;
  logic          hit;

  irt_mem #(.DEPTH(CAPACITY), .AW(AW)) u_mem (
    .clk(clk), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .rd_addr(rd_addr), .rd_data(rd_data)
  );

  assign busy = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item = out_r;

  // Window match for the entry that was just read.
  assign hit = (cmd_r.func == FN_LIST)
            || ((rd_data.s < cmd_r.start_time) && (rd_data.e > cmd_r.start_time))
            || ((rd_data.s >= cmd_r.start_time) && (rd_data.s < cmd_r.end_time));

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    cmd_nxt = cmd_r;
    count_nxt = count_r;
    next_id_nxt = next_id_r;
    idx_nxt = idx_r;
    j_nxt = j_r;
    pos_nxt = pos_r;
    pos_found_nxt = pos_found_r;
    hits_nxt = hits_r;
    pend_nxt = pend_r;
    pend_ent_nxt = pend_ent_r;
    out_valid_nxt = 1'b0;
    out_nxt = '0;
    wr_en = 1'b0;
    wr_addr = j_r[AW-1:0];
    wr_data = rd_data;
    rd_addr = idx_r[AW-1:0];
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd_nxt = in_item;
          idx_nxt = '0;
          pos_found_nxt = 1'b0;
          hits_nxt = '0;
          pend_nxt = 1'b0;
          if (in_item.func == FN_CREATE && in_item.start_time >= in_item.end_time) begin
            out_valid_nxt = 1'b1;
            out_nxt.status = ST_BAD_RANGE;
            out_nxt.last = 1'b1;
          end else if (count_r == '0) begin
            state_nxt = S_END;
          end else begin
            state_nxt = S_SC_RD;
          end
        end
      end
      S_SC_RD: begin
        state_nxt = S_SC_CK;
      end
      S_SC_CK: begin
        state_nxt = (idx_r + 1'b1 == count_r) ? S_END : S_SC_RD;
        idx_nxt = idx_r + 1'b1;
        case (cmd_r.func)
          FN_CREATE: begin
            if (cmd_r.start_time < rd_data.e && cmd_r.end_time > rd_data.s) begin
              out_valid_nxt = 1'b1;
              out_nxt.status = ST_OVERLAP;
              out_nxt.last = 1'b1;
              state_nxt = S_IDLE;
            end else if (!pos_found_r && rd_data.s >= cmd_r.start_time) begin
              pos_found_nxt = 1'b1;
              pos_nxt = idx_r;
            end
          end
          FN_DELETE: begin
            if (rd_data.id == cmd_r.target_id) begin
              out_valid_nxt = 1'b1;
              out_nxt = '{ST_OK, rd_data.id, rd_data.s, rd_data.e, 1'b1};
              j_nxt = idx_r;
              if (idx_r + 1'b1 < count_r) begin
                state_nxt = S_SH_RD;
              end else begin
                count_nxt = count_r - 1'b1;
                state_nxt = S_IDLE;
              end
            end
          end
          default: begin
            if (hit) begin
              if (pend_r) begin
                out_valid_nxt = 1'b1;
                out_nxt = '{ST_OK, pend_ent_r.id, pend_ent_r.s, pend_ent_r.e, 1'b0};
              end
              pend_nxt = 1'b1;
              pend_ent_nxt = rd_data;
              hits_nxt = hits_r + 1'b1;
              if (hits_r == HW'(MAX_OUT - 1)) begin
                state_nxt = S_END;
              end
            end
          end
        endcase
      end
      S_END: begin
        state_nxt = S_IDLE;
        out_valid_nxt = 1'b1;
        out_nxt.last = 1'b1;
        case (cmd_r.func)
          FN_CREATE: begin
            if (count_r >= CAP) begin
              out_nxt.status = ST_FULL;
            end else if (next_id_r == '0) begin
              out_nxt.status = ST_IDS_EXHAUSTED;
            end else begin
              out_valid_nxt = 1'b0;
              j_nxt = count_r;
              if (!pos_found_r) begin
                pos_nxt = count_r;
                state_nxt = S_INS;
              end else begin
                state_nxt = S_SH_RD;
              end
            end
          end
          FN_DELETE: begin
            out_nxt.status = ST_NOT_FOUND;
          end
          default: begin
            if (pend_r) begin
              out_nxt = '{ST_OK, pend_ent_r.id, pend_ent_r.s, pend_ent_r.e, 1'b1};
            end else begin
              out_nxt.status = ST_NO_EVENTS;
            end
          end
        endcase
      end
      S_SH_RD: begin
        // Create moves entries up, delete moves them down.
        rd_addr = (cmd_r.func == FN_CREATE) ? AW'(j_r - 1'b1) : AW'(j_r + 1'b1);
        state_nxt = S_SH_WR;
      end
      S_SH_WR: begin
        wr_en = 1'b1;
        if (cmd_r.func == FN_CREATE) begin
          j_nxt = j_r - 1'b1;
          state_nxt = (j_r - 1'b1 == pos_r) ? S_INS : S_SH_RD;
        end else begin
          j_nxt = j_r + 1'b1;
          if (j_r + 2'd2 < {1'b0, count_r}) begin
            state_nxt = S_SH_RD;
          end else begin
            count_nxt = count_r - 1'b1;
            state_nxt = S_IDLE;
          end
        end
      end
      S_INS: begin
        wr_en = 1'b1;
        wr_addr = pos_r[AW-1:0];
        wr_data = '{cmd_r.start_time, cmd_r.end_time, next_id_r};
        out_valid_nxt = 1'b1;
        out_nxt = '{ST_OK, next_id_r, cmd_r.start_time, cmd_r.end_time, 1'b1};
        count_nxt = count_r + 1'b1;
        next_id_nxt = next_id_r + 16'd1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      next_id_r <= 16'd1;
      out_valid_r <= 1'b0;
      pend_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      next_id_r <= next_id_nxt;
      out_valid_r <= out_valid_nxt;
      pend_r <= pend_nxt;
    end
  end

  // Payload and walk registers.
  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    idx_r <= idx_nxt;
    j_r <= j_nxt;
    pos_r <= pos_nxt;
    pos_found_r <= pos_found_nxt;
    hits_r <= hits_nxt;
    pend_ent_r <= pend_ent_nxt;
    out_r <= out_nxt;
  end

  // The table never holds more than its capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n) count_r <= CAP)
    else $error("entry count above capacity");

  // An accepted operation either raises busy or answers at once.
  a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> (busy || out_valid))
    else $error("accepted operation neither raised busy nor answered");

  // Error and no-events results are final and carry no id.
  a_err_final: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.status != ST_OK) |-> (out_item.last && out_item.entry_id == '0))
    else $error("error result not final or with an id");

  // Results in the middle of a listing only come from a walk.
  a_mid_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last) |-> busy)
    else $error("non-final result while idle");

endmodule
`default_nettype wire
